[rtl/core/pcxrle_pkg.sv]
// Shared types, constants and helpers for the PCX RLE scanline decoder.
package pcxrle_pkg;

    localparam int MAX_DIMENSION = 4096;
    localparam int CFG_W         = 13;
    localparam int CFG_IDX_W     = 2;
    localparam int DIM_W         = $clog2(MAX_DIMENSION + 1);
    localparam int COORD_W       = 12;
    localparam int REM_W         = $clog2(MAX_DIMENSION * MAX_DIMENSION + 1);
    localparam int RUN_W         = 6;
    localparam int ERR_W         = 3;

    localparam logic [7:0]       TOKEN_MASK = 8'hc0;
    localparam logic [RUN_W-1:0] COUNT_MASK = 6'h3f;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 2'd2;

    localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
    localparam logic [ERR_W-1:0] ERR_ZERO_RUN  = 3'd1;
    localparam logic [ERR_W-1:0] ERR_OVERRUN   = 3'd2;
    localparam logic [ERR_W-1:0] ERR_TRUNCATED = 3'd3;
    localparam logic [ERR_W-1:0] ERR_TRAILING  = 3'd4;

    typedef struct packed {
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [DIM_W-1:0] s;
    } geom_t;

    typedef struct packed {
        logic [7:0]       value;
        logic [RUN_W-1:0] count;
        logic             is_err;
        logic [ERR_W-1:0] err;
        logic             stream_end;
        logic             trunc;
    } cmd_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (32'(v) > 32'(MAX_DIMENSION))
            r = DIM_W'(MAX_DIMENSION);
        else
            r = DIM_W'(v);
        return r;
    endfunction

endpackage

[rtl/core/pcxrle_if.sv]
// Valid/ready stream interfaces for compressed bytes and decoded pixels.
interface pcxrle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_end;

    modport source (output valid, output data_byte, output stream_end, input ready);
    modport sink (input valid, input data_byte, input stream_end, output ready);
endinterface

interface pcxrle_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  pixel_value;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic        image_done;
    logic [2:0]  error_code;
    logic        last_of_item;

    modport source (output valid, output pixel_value, output pixel_x, output pixel_y,
                    output image_done, output error_code, output last_of_item,
                    input ready);
    modport sink (input valid, input pixel_value, input pixel_x, input pixel_y,
                  input image_done, input error_code, input last_of_item,
                  output ready);
endinterface

[rtl/core/pcxrle_front.sv]
// Front end: config registers, token parsing, overrun check and command issue.
module pcxrle_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [pcxrle_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pcxrle_pkg::CFG_W-1:0]         cfg_data,
    pcxrle_in_if.sink                            byte_in,
    output pcxrle_pkg::geom_t                    geom,
    output logic                                 cmd_valid,
    output pcxrle_pkg::cmd_t                     cmd,
    input  logic                                 cmd_ready
);
    import pcxrle_pkg::*;

    localparam logic [1:0] PH_TOKEN = 2'd0;
    localparam logic [1:0] PH_VALUE = 2'd1;
    localparam logic [1:0] PH_DONE  = 2'd2;
    localparam logic [1:0] PH_DRAIN = 2'd3;

    logic [CFG_W-1:0] width_reg, height_reg, stride_reg;
    logic [1:0]       phase_reg, phase_next;
    logic [RUN_W-1:0] run_reg, run_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic             fresh_reg, fresh_next;

    logic [DIM_W-1:0]   stride_c;
    logic [2*DIM_W-1:0] product;
    logic [REM_W-1:0]   total, rem_cur, rem_after;
    logic [RUN_W-1:0]   count, tok_count;
    logic               accept, is_token, cfg_hit;

    assign geom.w   = clamp_dim(width_reg);
    assign geom.h   = clamp_dim(height_reg);
    assign stride_c = clamp_dim(stride_reg);
    assign geom.s   = (stride_c < geom.w) ? geom.w : stride_c;
    assign product  = geom.h * geom.s;
    assign total    = REM_W'(product);

    assign byte_in.ready = cmd_ready;
    assign accept        = byte_in.valid && cmd_ready;
    assign cfg_hit       = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT
                                      || cfg_index == REG_STRIDE);

    assign is_token  = (byte_in.data_byte & TOKEN_MASK) == TOKEN_MASK;
    assign tok_count = byte_in.data_byte[RUN_W-1:0] & COUNT_MASK;
    assign count     = (phase_reg == PH_VALUE) ? run_reg : RUN_W'(1);
    assign rem_cur   = fresh_reg ? total : rem_reg;
    assign rem_after = rem_cur - REM_W'(count);

    always_comb
    begin
        phase_next = phase_reg;
        run_next   = run_reg;
        rem_next   = rem_reg;
        fresh_next = fresh_reg;
        cmd_valid  = 1'b0;
        cmd        = '0;
        if (cfg_hit)
        begin
            phase_next = PH_TOKEN;
            run_next   = '0;
            fresh_next = 1'b1;
        end
        else if (accept)
        begin
            case (phase_reg)
                PH_DRAIN:
                begin
                    if (byte_in.stream_end)
                    begin
                        phase_next = PH_TOKEN;
                        fresh_next = 1'b1;
                    end
                end
                PH_DONE:
                begin
                    cmd_valid  = 1'b1;
                    cmd.is_err = 1'b1;
                    cmd.err    = ERR_TRAILING;
                end
                default:
                begin
                    if (phase_reg == PH_TOKEN && is_token)
                    begin
                        if (tok_count == '0 || byte_in.stream_end)
                        begin
                            cmd_valid  = 1'b1;
                            cmd.is_err = 1'b1;
                            cmd.err    = (tok_count == '0) ? ERR_ZERO_RUN : ERR_TRUNCATED;
                        end
                        else
                        begin
                            run_next   = tok_count;
                            phase_next = PH_VALUE;
                        end
                    end
                    else if (REM_W'(count) > rem_cur)
                    begin
                        cmd_valid  = 1'b1;
                        cmd.is_err = 1'b1;
                        cmd.err    = ERR_OVERRUN;
                    end
                    else
                    begin
                        cmd_valid      = 1'b1;
                        cmd.value      = byte_in.data_byte;
                        cmd.count      = count;
                        cmd.stream_end = byte_in.stream_end;
                        cmd.trunc      = byte_in.stream_end && (rem_after != '0);
                        run_next       = '0;
                        rem_next       = rem_after;
                        fresh_next     = 1'b0;
                        if (byte_in.stream_end)
                        begin
                            phase_next = PH_TOKEN;
                            fresh_next = 1'b1;
                        end
                        else if (rem_after == '0)
                            phase_next = PH_DONE;
                        else
                            phase_next = PH_TOKEN;
                    end
                end
            endcase
            if (cmd.is_err)
            begin
                run_next = '0;
                if (byte_in.stream_end)
                begin
                    phase_next = PH_TOKEN;
                    fresh_next = 1'b1;
                end
                else
                    phase_next = PH_DRAIN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(1);
            height_reg <= CFG_W'(1);
            stride_reg <= CFG_W'(1);
            phase_reg  <= PH_TOKEN;
            run_reg    <= '0;
            rem_reg    <= '0;
            fresh_reg  <= 1'b1;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_WIDTH)
                width_reg <= cfg_data;
            if (cfg_we && cfg_index == REG_HEIGHT)
                height_reg <= cfg_data;
            if (cfg_we && cfg_index == REG_STRIDE)
                stride_reg <= cfg_data;
            phase_reg <= phase_next;
            run_reg   <= run_next;
            rem_reg   <= rem_next;
            fresh_reg <= fresh_next;
        end
    end

endmodule

[rtl/core/pcxrle_cmd_fifo.sv]
// Two-entry command queue between the front end and the expander.
module pcxrle_cmd_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pcxrle_pkg::cmd_t  push_cmd,
    output logic              not_full,
    input  logic              pop,
    output logic              head_valid,
    output pcxrle_pkg::cmd_t  head_cmd
);
    import pcxrle_pkg::*;

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg;

    assign not_full   = (fill_reg != 2'd2);
    assign head_valid = (fill_reg != 2'd0);
    assign head_cmd   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                fill_reg <= fill_reg + 2'd1;
            else if (pop && !push)
                fill_reg <= fill_reg - 2'd1;
        end
    end

endmodule

[rtl/core/pcxrle_back.sv]
// Back end: expands commands one decoded byte per cycle, while the output is not stalled, into pixel requests.
module pcxrle_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              restart,
    input  pcxrle_pkg::geom_t geom,
    input  logic              head_valid,
    input  pcxrle_pkg::cmd_t  head_cmd,
    output logic              pop,
    pcxrle_out_if.source      pixel_out
);
    import pcxrle_pkg::*;

    logic [COORD_W-1:0] col_reg, col_next;
    logic [DIM_W-1:0]   row_reg, row_next;
    logic [RUN_W-1:0]   step_reg, step_next;
    logic               tail_reg, tail_next;

    logic               out_valid_reg;
    logic [7:0]         value_reg;
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    logic               done_reg, last_reg;
    logic [ERR_W-1:0]   err_reg;

    logic               can_out, work, emit, emit_last, emit_done;
    logic [7:0]         emit_value;
    logic [ERR_W-1:0]   emit_err;
    logic [DIM_W-1:0]   col_ext, col_inc, gap;
    logic [RUN_W-1:0]   k_after;

    assign can_out = !out_valid_reg || pixel_out.ready;
    assign work    = head_valid && can_out;
    assign col_ext = DIM_W'(col_reg);
    assign col_inc = col_ext + DIM_W'(1);
    assign gap     = geom.s - col_ext;
    assign k_after = head_cmd.count - RUN_W'(1) - step_reg;

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        step_next  = step_reg;
        tail_next  = tail_reg;
        pop        = 1'b0;
        emit       = 1'b0;
        emit_last  = 1'b1;
        emit_done  = 1'b0;
        emit_value = '0;
        emit_err   = ERR_NONE;
        if (restart)
        begin
            col_next  = '0;
            row_next  = '0;
            step_next = '0;
            tail_next = 1'b0;
        end
        else if (work)
        begin
            if (head_cmd.is_err || tail_reg)
            begin
                emit      = 1'b1;
                emit_err  = tail_reg ? ERR_TRUNCATED : head_cmd.err;
                pop       = 1'b1;
                col_next  = '0;
                row_next  = '0;
                step_next = '0;
                tail_next = 1'b0;
            end
            else
            begin
                emit       = (col_ext < geom.w);
                emit_value = head_cmd.value;
                emit_done  = (row_reg == geom.h - DIM_W'(1))
                             && (col_ext == geom.w - DIM_W'(1));
                emit_last  = !head_cmd.trunc
                             && !((k_after != '0)
                                  && (col_inc < geom.w || DIM_W'(k_after) >= gap));
                if (col_inc >= geom.s)
                begin
                    col_next = '0;
                    row_next = row_reg + DIM_W'(1);
                end
                else
                    col_next = col_inc[COORD_W-1:0];
                if (k_after == '0)
                begin
                    step_next = '0;
                    if (head_cmd.trunc)
                        tail_next = 1'b1;
                    else
                    begin
                        pop = 1'b1;
                        if (head_cmd.stream_end)
                        begin
                            col_next = '0;
                            row_next = '0;
                        end
                    end
                end
                else
                    step_next = step_reg + RUN_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (work && emit)
        begin
            value_reg <= emit_value;
            x_reg     <= (emit_err == ERR_NONE) ? col_reg : '0;
            y_reg     <= (emit_err == ERR_NONE) ? row_reg[COORD_W-1:0] : '0;
            done_reg  <= emit_done;
            err_reg   <= emit_err;
            last_reg  <= emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            step_reg      <= '0;
            tail_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            step_reg <= step_next;
            tail_reg <= tail_next;
            if (can_out)
                out_valid_reg <= work && emit && !restart;
        end
    end

    assign pixel_out.valid        = out_valid_reg;
    assign pixel_out.pixel_value  = value_reg;
    assign pixel_out.pixel_x      = x_reg;
    assign pixel_out.pixel_y      = y_reg;
    assign pixel_out.image_done   = done_reg;
    assign pixel_out.error_code   = err_reg;
    assign pixel_out.last_of_item = last_reg;

endmodule

[rtl/core/pcx_rle_scanline_decoder.sv]
// PCX 8-bit RLE scanline decoder top level.
// Path: an accepted byte's command is written into the queue, then its request into the output reg.
// Expander: retires one decoded byte per cycle while the output is not stalled; a run is expanded
// byte by byte, a truncated end adds an error request, and padding bytes emit no request.
// Reset: async active low; control state clears, registers return to 1, no clearing pass.
module pcx_rle_scanline_decoder (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pcxrle_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pcxrle_pkg::CFG_W-1:0]      cfg_data,
    pcxrle_in_if.sink                         byte_in,
    pcxrle_out_if.source                      pixel_out
);
    import pcxrle_pkg::*;

    geom_t geom;
    cmd_t  push_cmd, head_cmd;
    logic  push, not_full, pop, head_valid;
    logic  cfg_restart;

    // only writes to a real register restart the decoder
    assign cfg_restart = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT
                                    || cfg_index == REG_STRIDE);

    pcxrle_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .byte_in   (byte_in),
        .geom      (geom),
        .cmd_valid (push),
        .cmd       (push_cmd),
        .cmd_ready (not_full)
    );

    pcxrle_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .not_full   (not_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    pcxrle_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (cfg_restart),
        .geom       (geom),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .pixel_out  (pixel_out)
    );

endmodule

[rtl/core/pcxrle_checker.sv]
// Port-level assertions for the decoder and their bind to the top level.
module pcxrle_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  pixel_value,
    input logic [11:0] pixel_x,
    input logic [11:0] pixel_y,
    input logic        image_done,
    input logic [2:0]  error_code,
    input logic        last_of_item
);
    import pcxrle_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_value) && $stable(pixel_x)
            && $stable(pixel_y) && $stable(error_code) && $stable(last_of_item))
        else $error("stalled request changed");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code != ERR_NONE |-> last_of_item)
        else $error("error request not last of its byte");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code != ERR_NONE |->
            pixel_value == 8'd0 && pixel_x == 12'd0 && pixel_y == 12'd0 && !image_done)
        else $error("error request carries pixel data");

    // a truncated end may still follow the final pixel when line padding is missing
    a_done_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && image_done |-> error_code == ERR_NONE)
        else $error("final pixel flagged as error");

endmodule

bind pcx_rle_scanline_decoder pcxrle_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (pixel_out.valid),
    .out_ready    (pixel_out.ready),
    .pixel_value  (pixel_out.pixel_value),
    .pixel_x      (pixel_out.pixel_x),
    .pixel_y      (pixel_out.pixel_y),
    .image_done   (pixel_out.image_done),
    .error_code   (pixel_out.error_code),
    .last_of_item (pixel_out.last_of_item)
);
